FILE: sv/rmea_pkg.sv
// rmea_pkg: shared types and constants for the rotation matrix to euler angles block
// depends on nothing
`default_nettype none
package rmea_pkg;

   localparam int unsigned ELEM_W   = 16;
   localparam int unsigned ANGLE_W  = 16;
   localparam int unsigned THRESH_W = 15;
   localparam int unsigned TABLE_LEN = 24;
   localparam int unsigned Z_W      = 34;
   localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd1;

   typedef struct packed {
      logic signed [ELEM_W-1:0] m00;
      logic signed [ELEM_W-1:0] m10;
      logic signed [ELEM_W-1:0] m11;
      logic signed [ELEM_W-1:0] m12;
      logic signed [ELEM_W-1:0] m20;
      logic signed [ELEM_W-1:0] m21;
      logic signed [ELEM_W-1:0] m22;
   } req_payload_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
      logic                      is_singular;
   } rsp_payload_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
      logic signed [Z_W-1:0] r;
      case (i)
         0: r = 34'sh3243F6A8;
         1: r = 34'sh1DAC6705;
         2: r = 34'sh0FADBAFC;
         3: r = 34'sh07F56EA6;
         4: r = 34'sh03FEAB76;
         5: r = 34'sh01FFD55B;
         6: r = 34'sh00FFFAAA;
         7: r = 34'sh007FFF55;
         8: r = 34'sh003FFFEA;
         9: r = 34'sh001FFFFD;
         10: r = 34'sh000FFFFF;
         11: r = 34'sh0007FFFF;
         12: r = 34'sh0003FFFF;
         13: r = 34'sh0001FFFF;
         14: r = 34'sh0000FFFF;
         15: r = 34'sh00007FFF;
         16: r = 34'sh00003FFF;
         17: r = 34'sh00001FFF;
         18: r = 34'sh00000FFF;
         19: r = 34'sh000007FF;
         20: r = 34'sh000003FF;
         21: r = 34'sh000001FF;
         22: r = 34'sh000000FF;
         23: r = 34'sh0000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/rmea_isqrt.sv
// rmea_isqrt: pipelined restoring square root, one result bit per stage
// depends on rmea_pkg
`default_nettype none
module rmea_isqrt #(
   parameter int unsigned IN_W = 32
) (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [IN_W-1:0]   radicand,
   output logic      [IN_W/2-1:0] root
);
   import rmea_pkg::*;

   localparam int unsigned STEPS = IN_W / 2;

   logic [IN_W-1:0]  rem_ff  [STEPS+1];
   logic [IN_W-1:0]  val_ff  [STEPS+1];
   logic [STEPS-1:0] root_ff [STEPS+1];

   always_comb begin
      rem_ff[0]  = '0;
      val_ff[0]  = radicand;
      root_ff[0] = '0;
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [IN_W+1:0] rem_in;
      logic [IN_W+1:0] trial_in;
      always_comb begin
         rem_in   = {rem_ff[s], val_ff[s][IN_W-1 -: 2]};
         trial_in = {{(IN_W-STEPS){1'b0}}, root_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            val_ff[s+1] <= val_ff[s] << 2;
            if (rem_in >= trial_in) begin
               rem_ff[s+1]  <= IN_W'(rem_in - trial_in);
               root_ff[s+1] <= {root_ff[s][STEPS-2:0], 1'b1};
            end else begin
               rem_ff[s+1]  <= IN_W'(rem_in);
               root_ff[s+1] <= {root_ff[s][STEPS-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[STEPS];
endmodule
`default_nettype wire

FILE: sv/rmea_cordic.sv
// rmea_cordic: pipelined vectoring cordic atan2, q3.13 saturated angle out
// depends on rmea_pkg
`default_nettype none
module rmea_cordic #(
   parameter int unsigned STAGES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic signed [rmea_pkg::ELEM_W:0] y_in,
   input  wire logic signed [rmea_pkg::ELEM_W:0] x_in,
   output logic      signed [rmea_pkg::ANGLE_W-1:0] angle
);
   import rmea_pkg::*;

   localparam int unsigned N = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
   localparam int unsigned V_W = ELEM_W + 1 + 14 + 3;

   logic signed [V_W-1:0] x_ff [N+1];
   logic signed [V_W-1:0] y_ff [N+1];
   logic signed [Z_W-1:0] z_ff [N+1];
   logic                  zero_ff [N+1];
   logic signed [Z_W-1:0] zr_in;
   logic signed [Z_W-1:0] zo_ff;
   logic                  zz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -(V_W'(x_in) <<< 14);
            y_ff[0] <= -(V_W'(y_in) <<< 14);
            z_ff[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
         end else begin
            x_ff[0] <= V_W'(x_in) <<< 14;
            y_ff[0] <= V_W'(y_in) <<< 14;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zo_ff <= (z_ff[N] + Z_W'(65536)) >>> 17;
         zz_ff <= zero_ff[N];
      end
   end

   always_comb begin
      zr_in = zo_ff;
      if (zz_ff) angle = '0;
      else if (zr_in > Z_W'(ANGLE_LIMIT)) angle = ANGLE_LIMIT;
      else if (zr_in < -Z_W'(ANGLE_LIMIT)) angle = -ANGLE_LIMIT;
      else angle = ANGLE_W'(zr_in);
   end
endmodule
`default_nettype wire

FILE: sv/rotation_matrix_to_euler_angles.sv
// rotation_matrix_to_euler_angles: top level, zyx euler angles from a rotation matrix
// depends on rmea_pkg, rmea_isqrt, rmea_cordic
//
// usage:
//   req_ channel carries one matrix beat (seven q2.14 elements), rsp_ channel
//   one angle beat (roll, pitch, yaw in q3.13 plus singular flag).
//   csr_ channel writes singular_threshold, always ready; write only when idle.
//   pipeline: 1 squaring stage, ELEM_W root stages, then three cordic units in
//   parallel (pitch, roll, yaw) of CORDIC_STAGES+2 stages each, then an output
//   register.
//   the root and cordic chains set the latency; cordic stages are capped at 24.
//   throughput: one beat per cycle while the receiver does not stall.
//   when the receiver stalls the whole pipeline holds; req_ready is low only
//   while the output register holds a beat that is not taken.
//   reset clears the valid bits and sets the threshold to 1.
`default_nettype none
module rotation_matrix_to_euler_angles #(
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rmea_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rmea_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [rmea_pkg::THRESH_W-1:0] csr_data
);
   import rmea_pkg::*;

   localparam int unsigned SQ_W  = 2 * ELEM_W;
   localparam int unsigned RT_W  = ELEM_W;
   localparam int unsigned RT_LAT = RT_W;
   localparam int unsigned CD_LAT =
      ((CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES) + 2;
   localparam int unsigned OUT_AT = RT_LAT + CD_LAT;
   localparam int unsigned DEPTH = OUT_AT + 1;

   logic advance;
   logic [THRESH_W-1:0] thresh_ff;
   logic [DEPTH-1:0] vld_ff;
   rsp_payload_type out_ff;
   logic out_vld_ff;

   // stage 0: squares
   req_payload_type p0_ff;
   logic [SQ_W-1:0] sum0_ff;
   logic [RT_W-1:0] sy;

   assign advance = !out_vld_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= THRESH_RESET;
      else if (csr_valid) thresh_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff   <= req_payload;
         sum0_ff <= SQ_W'($unsigned(32'(req_payload.m00) * 32'(req_payload.m00)))
                  + SQ_W'($unsigned(32'(req_payload.m10) * 32'(req_payload.m10)));
      end
   end

   rmea_isqrt #(.IN_W(SQ_W)) u_isqrt (
      .clock(clock), .advance(advance), .radicand(sum0_ff), .root(sy));

   // delay line for matrix during root
   req_payload_type pd_ff [RT_LAT+1];
   always_comb pd_ff[0] = p0_ff;
   for (genvar k = 0; k < RT_LAT; k++) begin : g_pd
      always_ff @(posedge clock) if (advance) pd_ff[k+1] <= pd_ff[k];
   end

   logic sing;
   assign sing = {1'b0, sy} < {{(RT_W+1-THRESH_W){1'b0}}, thresh_ff};

   // three cordic units side by side: pitch, roll, yaw
   logic signed [ELEM_W:0] pitch_y, pitch_x, roll_y, roll_x;
   assign pitch_y = -(ELEM_W+1)'(pd_ff[RT_LAT].m20);
   assign pitch_x = (ELEM_W+1)'($signed({1'b0, sy}));
   assign roll_y  = sing ? -(ELEM_W+1)'(pd_ff[RT_LAT].m12) : (ELEM_W+1)'(pd_ff[RT_LAT].m21);
   assign roll_x  = sing ? (ELEM_W+1)'(pd_ff[RT_LAT].m11) : (ELEM_W+1)'(pd_ff[RT_LAT].m22);

   logic signed [ANGLE_W-1:0] pitch_a, roll_a, yaw_a;
   rmea_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .advance(advance), .y_in(pitch_y), .x_in(pitch_x), .angle(pitch_a));
   rmea_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .advance(advance), .y_in(roll_y), .x_in(roll_x), .angle(roll_a));
   rmea_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .advance(advance),
      .y_in((ELEM_W+1)'(pd_ff[RT_LAT].m10)), .x_in((ELEM_W+1)'(pd_ff[RT_LAT].m00)),
      .angle(yaw_a));

   logic sd_ff [CD_LAT+1];
   always_comb sd_ff[0] = sing;
   for (genvar k = 0; k < CD_LAT; k++) begin : g_sd
      always_ff @(posedge clock) if (advance) sd_ff[k+1] <= sd_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= vld_ff[OUT_AT];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.roll_angle  <= roll_a;
         out_ff.pitch_angle <= pitch_a;
         out_ff.yaw_angle   <= sd_ff[CD_LAT] ? '0 : yaw_a;
         out_ff.is_singular <= sd_ff[CD_LAT];
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;
endmodule
`default_nettype wire

FILE: sv/rmea_checker.sv
// rmea_checker: port level assertions for the euler angle block
// depends on rmea_pkg, rotation_matrix_to_euler_angles
`default_nettype none
module rmea_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rmea_pkg::rsp_payload_type rsp_payload
);
   import rmea_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_singular |-> rsp_payload.yaw_angle == '0)
      else $error("yaw not zero when singular");
   a_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.roll_angle <= ANGLE_LIMIT
                 && rsp_payload.roll_angle >= -ANGLE_LIMIT)
      else $error("roll out of range");
endmodule

bind rotation_matrix_to_euler_angles rmea_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload));
`default_nettype wire

FILE: bench/tb_rotation_matrix_to_euler_angles.sv
// tb_rotation_matrix_to_euler_angles: self-checking bench for the zyx euler angle block
// depends on rmea_pkg and rotation_matrix_to_euler_angles; predicts every angle beat
// from the matrix beat and checks it field by field, with random gaps on both sides
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler_angles;
   import rmea_pkg::*;

   localparam int LATENCY = 16 + 19;
   localparam int STALL_LIMIT = 20000;
   localparam longint PI_Q30_VAL = 64'sd3373259426;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THRESH_W-1:0] csr_data = '0;

   rsp_payload_type angle_queue[$];
   logic [THRESH_W-1:0] threshold;
   int errors = 0;
   int idle_cycles = 0;
   int rsp_gap = 0;
   bit hold_rsp = 1'b0;
   bit rsp_burst = 1'b0;

   rotation_matrix_to_euler_angles u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint n);
      longint root;
      longint b;
      root = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >>> 1) + b;
         end else begin
            root = root >>> 1;
         end
         b = b >>> 2;
      end
      return root;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] angle_of(longint y, longint x);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      if (x == 0 && y == 0) return '0;
      x = x * 16384;
      y = y * 16384;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q30_VAL : -PI_Q30_VAL;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atan_entry(i));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atan_entry(i));
         end
      end
      z = shift_floor(z + 65536, 17);
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z[ANGLE_W-1:0];
   endfunction

   function automatic rsp_payload_type euler_of(req_payload_type m);
      rsp_payload_type r;
      longint sy;
      sy = root_floor(longint'(m.m00) * m.m00 + longint'(m.m10) * m.m10);
      r.is_singular = sy < longint'(threshold);
      r.pitch_angle = angle_of(-longint'(m.m20), sy);
      if (!r.is_singular) begin
         r.roll_angle = angle_of(m.m21, m.m22);
         r.yaw_angle = angle_of(m.m10, m.m00);
      end else begin
         r.roll_angle = angle_of(-longint'(m.m12), m.m11);
         r.yaw_angle = '0;
      end
      return r;
   endfunction

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return ELEM_W'($urandom);
      if (k == 1) return ELEM_W'($urandom_range(0, 8)) - 16'sd4;
      return ELEM_W'($urandom_range(0, 32768)) - 16'sd16384;
   endfunction

   function automatic req_payload_type rand_matrix();
      req_payload_type m;
      m.m00 = rand_elem();
      m.m10 = rand_elem();
      m.m11 = rand_elem();
      m.m12 = rand_elem();
      m.m20 = rand_elem();
      m.m21 = rand_elem();
      m.m22 = rand_elem();
      if ($urandom_range(0, 4) == 0) begin
         m.m00 = ELEM_W'($urandom_range(0, 40)) - 16'sd20;
         m.m10 = ELEM_W'($urandom_range(0, 40)) - 16'sd20;
      end
      return m;
   endfunction

   function automatic int gap_len();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) n = 0;
      return n;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   // with req_valid still high, so back to back beats need no extra edge
   task automatic send_matrix(req_payload_type m, bit gaps);
      int n;
      n = gaps ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      angle_queue.insert(angle_queue.size(), euler_of(m));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (angle_queue.size() != 0) @(negedge clock);
   endtask

   task automatic set_threshold(logic [THRESH_W-1:0] v);
      drain();
      repeat (LATENCY + 4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // directed rows; expected typed in where obvious
   typedef struct {
      req_payload_type m;
      bit known;
      rsp_payload_type r;
   } row_type;

   row_type rows[$];

   task automatic add_row(int a, int b, int c, int d, int e, int f, int g,
                          bit known, int ro, int pi, int ya, bit s);
      row_type t;
      t.m = '{a[15:0], b[15:0], c[15:0], d[15:0], e[15:0], f[15:0], g[15:0]};
      t.known = known;
      t.r = '{ro[15:0], pi[15:0], ya[15:0], s};
      rows.insert(rows.size(), t);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (angle_queue.size() == 0) begin
            $error("angle beat with nothing expected");
            errors++;
         end else begin
            rsp_payload_type e;
            e = angle_queue.pop_front();
            if (rsp_payload.roll_angle !== e.roll_angle) begin
               $error("roll_angle exp %0d got %0d", e.roll_angle, rsp_payload.roll_angle);
               errors++;
            end
            if (rsp_payload.pitch_angle !== e.pitch_angle) begin
               $error("pitch_angle exp %0d got %0d", e.pitch_angle, rsp_payload.pitch_angle);
               errors++;
            end
            if (rsp_payload.yaw_angle !== e.yaw_angle) begin
               $error("yaw_angle exp %0d got %0d", e.yaw_angle, rsp_payload.yaw_angle);
               errors++;
            end
            if (rsp_payload.is_singular !== e.is_singular) begin
               $error("is_singular exp %0d got %0d", e.is_singular, rsp_payload.is_singular);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: held off on hold_rsp, always ready in a burst, else mostly short gaps and a few long ones
   always @(negedge clock) begin
      if (hold_rsp) rsp_ready <= 1'b0;
      else if (rsp_burst) rsp_ready <= 1'b1;
      else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap = rsp_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_gap = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 2);
      end else rsp_ready <= 1'b1;
   end

   initial begin
      threshold = THRESH_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
      add_row(16384, 0, 16384, 0, 0, 0, 16384, 1, 0, 0, 0, 0);
      add_row(-16384, 0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
      add_row(0, -16384, 0, 0, -16384, 0, -16384, 0, 0, 0, 0, 0);
      add_row(-16384, -1, 0, 0, 16384, -1, -16384, 0, 0, 0, 0, 0);
      add_row(0, 0, -16384, 16384, 16384, 0, 0, 0, 0, 0, 0, 0);
      add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0);
      add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
      add_row(-32768, 32767, 1, -1, 0, -32768, -32768, 0, 0, 0, 0, 0);
      add_row(0, 0, 16384, -16384, 16384, 0, 0, 0, 0, 0, 0, 0);
      add_row(11585, 11585, 11585, -11585, 0, 11585, 11585, 0, 0, 0, 0, 0);
      foreach (rows[i]) begin
         send_matrix(rows[i].m, 1'b0);
         if (rows[i].known && angle_queue[$] !== rows[i].r) begin
            $error("table row %0d predictor disagrees", i);
            errors++;
         end
      end

      set_threshold(15'd16384);
      for (int i = 0; i < 6; i++) send_matrix(rows[i].m, 1'b0);
      set_threshold(15'd0);
      for (int i = 0; i < 6; i++) send_matrix(rows[i].m, 1'b0);
      set_threshold(15'd32767);
      send_matrix(rows[1].m, 1'b0);

      // receiver holds off while sender keeps pushing
      set_threshold(15'd100);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (LATENCY * 3) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 120; i++) send_matrix(rand_matrix(), 1'b0);
      join

      for (int i = 0; i < 560; i++) begin
         if (i % 140 == 0) begin
            set_threshold(THRESH_W'($urandom_range(0, 16384)));
            rsp_burst = $urandom_range(0, 1);
         end
         if (i == 280) drain();
         send_matrix(rand_matrix(), 1'b1);
      end

      drain();
      repeat (LATENCY + 10) @(negedge clock);
      if (errors == 0 && angle_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
